[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define SALSU_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("salsu port check failed");

// checked on every edge, reset included
`define SALSU_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("salsu reset check failed");

`endif

[hw/rtl/salsu_pkg.sv]
package salsu_pkg;

    localparam int DATA_W    = 32;
    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int LANES     = 4;
    localparam int ROWS      = MEM_BYTES / LANES;
    localparam int ROW_W     = ADDR_W - 2;
    localparam int LUI_SHIFT = 16;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 40;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_SLL    = 4'd4,
        MODE_SRL    = 4'd5,
        MODE_SRA    = 4'd6,
        MODE_MOD    = 4'd7,
        MODE_MIN    = 4'd8,
        MODE_LUI    = 4'd9,
        MODE_LOAD   = 4'd10,
        MODE_ASSIGN = 4'd11,
        MODE_STORE  = 4'd12
    } t_mode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_LOAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        logic                clearing;
        logic [DATA_W-1:0]   rdata;
    } t_mem_rsp;

    typedef struct packed {
        logic                start;
        logic [DATA_W-1:0]   dividend;
        logic [DATA_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DATA_W-1:0]   quot;
        logic [DATA_W-1:0]   rem;
    } t_div_rsp;

endpackage

[hw/rtl/salsu_div.sv]
module salsu_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  salsu_pkg::t_div_req i_req,
    output salsu_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(salsu_pkg::DATA_W);

    logic                          r_busy;
    logic                          r_fix;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [salsu_pkg::DATA_W-1:0]  r_rem;
    logic [salsu_pkg::DATA_W-1:0]  r_quo;
    logic [salsu_pkg::DATA_W-1:0]  r_dvs;
    logic                          r_neg_q;
    logic                          r_neg_r;

    logic [salsu_pkg::DATA_W-1:0]  abs_a;
    logic [salsu_pkg::DATA_W-1:0]  abs_b;
    logic [salsu_pkg::DATA_W:0]    shifted;
    logic [salsu_pkg::DATA_W:0]    diff;

    assign abs_a   = i_req.dividend[salsu_pkg::DATA_W-1] ? -i_req.dividend : i_req.dividend;
    assign abs_b   = i_req.divisor[salsu_pkg::DATA_W-1]  ? -i_req.divisor  : i_req.divisor;
    assign shifted = {r_rem, r_quo[salsu_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fix;
            r_fix  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle on magnitudes, sign fixed at the end
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= '0;
            r_quo   <= abs_a;
            r_dvs   <= abs_b;
            r_neg_q <= i_req.dividend[salsu_pkg::DATA_W-1] ^ i_req.divisor[salsu_pkg::DATA_W-1];
            r_neg_r <= i_req.dividend[salsu_pkg::DATA_W-1];
        end else if (r_busy) begin
            r_rem <= diff[salsu_pkg::DATA_W] ? shifted[salsu_pkg::DATA_W-1:0]
                                             : diff[salsu_pkg::DATA_W-1:0];
            r_quo <= {r_quo[salsu_pkg::DATA_W-2:0], ~diff[salsu_pkg::DATA_W]};
        end else if (r_fix) begin
            r_quo <= r_neg_q ? -r_quo : r_quo;
            r_rem <= r_neg_r ? -r_rem : r_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[hw/rtl/salsu_mem.sv]
module salsu_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  salsu_pkg::t_mem_req i_req,
    output salsu_pkg::t_mem_rsp o_rsp
);

    logic                          r_clearing;
    logic [salsu_pkg::ROW_W-1:0]   r_clr_row;
    logic [1:0]                    r_sel;
    logic [7:0]                    w_q [salsu_pkg::LANES];

    // clearing sweep after reset, one row of all banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (&r_clr_row) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_sel <= i_req.addr[1:0];
        end
    end

    // bank k holds bytes whose address is k modulo 4
    for (genvar k = 0; k < salsu_pkg::LANES; k++) begin : g_bank
        logic [7:0]                    r_ram [salsu_pkg::ROWS];
        logic [7:0]                    r_q;
        logic [1:0]                    lane;
        logic [salsu_pkg::ADDR_W-1:0]  byte_addr;
        logic [salsu_pkg::ROW_W-1:0]   row;
        logic [7:0]                    wbyte;

        assign lane      = 2'(k) - i_req.addr[1:0];
        assign byte_addr = i_req.addr + salsu_pkg::ADDR_W'(lane);
        assign row       = byte_addr[salsu_pkg::ADDR_W-1:2];
        assign wbyte     = i_req.wdata[8*lane +: 8];

        always_ff @(posedge i_clk) begin
            if (r_clearing) begin
                r_ram[r_clr_row] <= '0;
            end else if (i_req.en && i_req.we) begin
                r_ram[row] <= wbyte;
            end
            if (i_req.en && !i_req.we) begin
                r_q <= r_ram[row];
            end
        end

        assign w_q[k] = r_q;
    end

    // put bytes back in word order
    always_comb begin
        o_rsp.clearing = r_clearing;
        for (int i = 0; i < salsu_pkg::LANES; i++) begin
            o_rsp.rdata[8*i +: 8] = w_q[2'(r_sel + 2'(i))];
        end
    end

endmodule

[hw/rtl/scalar_alu_load_store_unit_core.sv]
// channel   | dir | beat fields
// s_axis    | in  | tdata: mode, src_a, src_b, addr_offset, dest_index; tuser: special_flag
// m_axis    | out | tdata: write_enable, write_index, write_value; tuser: write_special
//
// from accept to result valid: alu ops and division by zero pass S_EXEC and S_DONE, load adds
//   S_LOAD (scratchpad read), div and mod add S_DIV (one quotient bit per cycle); S_IDLE follows each
// one item at a time: a new beat is taken once the previous result sits in the output register
// reset: synchronous, active low; afterwards the scratchpad is swept to zero row by row,
//   MEM_BYTES/4 = 1024 rows, while s_axis tready stays low
// a stalled m_axis holds the result in the output register and the next result waits behind it
module scalar_alu_load_store_unit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // mode[3:0], src_a[35:4], src_b[67:36], addr_offset[99:68], dest_index[104:100], zero
    input  logic [salsu_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // special_flag[0]
    input  logic [0:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // write_enable[0], write_index[5:1], write_value[37:6], zero
    output logic [salsu_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // write_special[0]
    output logic [0:0]                        o_m_axis_tuser
);

    // state and latched instruction
    salsu_pkg::t_state             r_state;
    salsu_pkg::t_state             n_state;
    salsu_pkg::t_mode              r_mode;
    logic [salsu_pkg::DATA_W-1:0]  r_a;
    logic [salsu_pkg::DATA_W-1:0]  r_b;
    logic [salsu_pkg::DATA_W-1:0]  r_off;
    logic [4:0]                    r_dest;
    logic                          r_spec;

    // finished result waiting for the output register
    logic                          r_res_we;
    logic [salsu_pkg::DATA_W-1:0]  r_res_val;
    logic                          r_res_spec;
    logic                          n_res_we;
    logic [salsu_pkg::DATA_W-1:0]  n_res_val;
    logic                          n_res_spec;

    // output register
    logic                          r_out_valid;
    logic                          r_out_we;
    logic [4:0]                    r_out_idx;
    logic [salsu_pkg::DATA_W-1:0]  r_out_val;
    logic                          r_out_spec;

    logic                          in_beat;
    logic                          out_free;
    logic                          is_divmod;
    logic                          div_bypass;
    logic                          res_cap;
    logic                          out_load;
    logic                          s_ready;
    logic [salsu_pkg::DATA_W-1:0]  alu_val;
    logic [salsu_pkg::DATA_W-1:0]  prod;

    salsu_pkg::t_mem_req           mem_req;
    salsu_pkg::t_mem_rsp           mem_rsp;
    salsu_pkg::t_div_req           div_req;
    salsu_pkg::t_div_rsp           div_rsp;

    salsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    salsu_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    assign in_beat    = i_s_axis_tvalid && s_ready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign is_divmod  = (r_mode == salsu_pkg::MODE_DIV) || (r_mode == salsu_pkg::MODE_MOD);
    // divide by zero needs no divider pass
    assign div_bypass = (r_b == '0);
    assign prod       = r_a * r_b;

    // latch the instruction on its beat
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mode <= salsu_pkg::t_mode'(i_s_axis_tdata[3:0]);
            r_a    <= i_s_axis_tdata[35:4];
            r_b    <= i_s_axis_tdata[67:36];
            r_off  <= i_s_axis_tdata[99:68];
            r_dest <= i_s_axis_tdata[104:100];
            r_spec <= i_s_axis_tuser[0];
        end
    end

    // combinational ops, with the divide-by-zero results for div and mod
    always_comb begin
        case (r_mode)
            salsu_pkg::MODE_ADD:    alu_val = r_a + r_b;
            salsu_pkg::MODE_SUB:    alu_val = r_a - r_b;
            salsu_pkg::MODE_MUL:    alu_val = prod;
            salsu_pkg::MODE_DIV:    alu_val = '1;
            salsu_pkg::MODE_MOD:    alu_val = r_a;
            salsu_pkg::MODE_SLL:    alu_val = r_a << r_b[4:0];
            salsu_pkg::MODE_SRL:    alu_val = r_a >> r_b[4:0];
            salsu_pkg::MODE_SRA:    alu_val = $unsigned($signed(r_a) >>> r_b[4:0]);
            salsu_pkg::MODE_MIN:    alu_val = ($signed(r_a) < $signed(r_b)) ? r_a : r_b;
            salsu_pkg::MODE_LUI:    alu_val = r_b << salsu_pkg::LUI_SHIFT;
            salsu_pkg::MODE_ASSIGN: alu_val = r_a;
            default:                alu_val = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            salsu_pkg::S_CLEAR: begin
                if (!mem_rsp.clearing) begin
                    n_state = salsu_pkg::S_IDLE;
                end
            end
            salsu_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_state = salsu_pkg::S_EXEC;
                end
            end
            salsu_pkg::S_EXEC: begin
                if (is_divmod && !div_bypass) begin
                    n_state = salsu_pkg::S_DIV;
                end else if (r_mode == salsu_pkg::MODE_LOAD) begin
                    n_state = salsu_pkg::S_LOAD;
                end else begin
                    n_state = salsu_pkg::S_DONE;
                end
            end
            salsu_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_state = salsu_pkg::S_DONE;
                end
            end
            salsu_pkg::S_LOAD: n_state = salsu_pkg::S_DONE;
            salsu_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = salsu_pkg::S_IDLE;
                end
            end
            default: n_state = salsu_pkg::S_CLEAR;
        endcase
    end

    // per-state outputs
    always_comb begin
        s_ready          = 1'b0;
        res_cap          = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_a;
        div_req.divisor  = r_b;
        mem_req.en       = 1'b0;
        mem_req.we       = (r_mode == salsu_pkg::MODE_STORE);
        mem_req.addr     = r_a[salsu_pkg::ADDR_W-1:0] + r_off[salsu_pkg::ADDR_W-1:0];
        mem_req.wdata    = r_b;
        n_res_we         = 1'b1;
        n_res_val        = alu_val;
        n_res_spec       = 1'b0;
        case (r_state)
            salsu_pkg::S_IDLE: s_ready = 1'b1;
            salsu_pkg::S_EXEC: begin
                div_req.start = is_divmod && !div_bypass;
                mem_req.en    = (r_mode == salsu_pkg::MODE_LOAD)
                             || (r_mode == salsu_pkg::MODE_STORE);
                res_cap       = !(is_divmod && !div_bypass) && (r_mode != salsu_pkg::MODE_LOAD);
                if (r_mode == salsu_pkg::MODE_ASSIGN) begin
                    n_res_spec = r_spec;
                end
                // store and unused codes write nothing
                if ((r_mode == salsu_pkg::MODE_STORE) || (r_mode > salsu_pkg::MODE_STORE)) begin
                    n_res_we = 1'b0;
                end
            end
            salsu_pkg::S_DIV: begin
                res_cap   = div_rsp.done;
                n_res_val = (r_mode == salsu_pkg::MODE_DIV) ? div_rsp.quot : div_rsp.rem;
            end
            salsu_pkg::S_LOAD: begin
                res_cap   = 1'b1;
                n_res_val = mem_rsp.rdata;
            end
            salsu_pkg::S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salsu_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_cap) begin
            r_res_we   <= n_res_we;
            r_res_val  <= n_res_we ? n_res_val : '0;
            r_res_spec <= n_res_we && n_res_spec;
        end
    end

    // output register, refilled only when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_we   <= r_res_we;
            r_out_idx  <= r_res_we ? r_dest : '0;
            r_out_val  <= r_res_val;
            r_out_spec <= r_res_spec;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_val, r_out_idx, r_out_we};
    assign o_m_axis_tuser  = r_out_spec;

endmodule

[hw/rtl/salsu_checker.sv]
`include "assert_macros.svh"

module salsu_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic [salsu_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic [0:0]                        i_s_axis_tuser,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [salsu_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic [0:0]                        o_m_axis_tuser
);

    // a held result beat does not change
    `SALSU_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // reset leaves no result and starts the clearing sweep
    `SALSU_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)

    // one instruction in flight: no beat taken right after another
    `SALSU_ASSERT(a_one_in_flight, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)

    // no write means an all-zero result
    `SALSU_ASSERT(a_nowrite_zero, o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[37:1] == 37'd0 && !o_m_axis_tuser[0])

    // special register writes only come with a write
    `SALSU_ASSERT(a_special_we, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[0])

endmodule

bind scalar_alu_load_store_unit_core salsu_checker u_salsu_checker (.*);

[sim/tb.sv]
module tb;

    // unused operation codes, the block treats them as no-ops
    localparam logic [3:0] MODE_RSVD_LO = 4'd13;
    localparam logic [3:0] MODE_RSVD_HI = 4'd15;

    localparam int RANDOM_ITEMS   = 500;
    localparam int CALM_ITEMS     = 60;     // tail of the run with no idling
    localparam int LONG_HOLD      = 200;    // receiver hold-off that backs up the block
    localparam int HOLD_SPACING   = 240;
    localparam int TAIL_CYCLES    = 48;     // longer than the divide latency
    localparam int WATCHDOG_LIMIT = 4096;   // covers the scratchpad sweep after reset
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic        drain;        // sender waits for all write-backs before this one
        logic [3:0]  mode;
        logic [31:0] src_a;
        logic [31:0] src_b;
        logic [31:0] addr_offset;
        logic [4:0]  dest_index;
        logic        special_flag;
    } t_instr;

    typedef struct packed {
        logic        we;
        logic [4:0]  index;
        logic [31:0] value;
        logic        special;
    } t_wb;

    logic                            i_clk;
    logic                            rst_n = 1'b0;
    logic                            tx_valid = 1'b0;
    t_instr                          tx_item = '0;
    logic                            rx_ready = 1'b0;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [salsu_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]                      o_m_axis_tuser;
    logic [salsu_pkg::S_TDATA_W-1:0] s_tdata;

    // instruction stream and the write-backs it should produce
    t_instr instr_queue[$];
    t_wb    expected_writebacks[$];
    logic [7:0] spad_model [salsu_pkg::MEM_BYTES] = '{default: 8'h00};

    int item_total   = 0;
    int taken_cnt    = 0;       // updated with nonblocking assignments only
    int results_seen = 0;       // updated with nonblocking assignments only
    int mismatches   = 0;
    int n_load       = 0;
    int n_store      = 0;
    int n_divmod     = 0;
    int n_unused     = 0;

    // sender side pacing, owned by the driver
    int tx_gap     = 0;
    int tx_offered = 0;
    bit tx_idle_on = 1'b1;

    // receiver side pacing, owned by the receiver process
    int rx_stall     = 0;
    int rx_cycle     = 0;
    int hold_left    = 0;
    int next_hold_at = 120;
    bit rx_idle_on   = 1'b1;

    int quiet_cycles = 0;

    // mode[3:0], src_a[35:4], src_b[67:36], addr_offset[99:68], dest_index[104:100], zero
    assign s_tdata = salsu_pkg::S_TDATA_W'({tx_item.dest_index, tx_item.addr_offset,
                                            tx_item.src_b, tx_item.src_a, tx_item.mode});

    scalar_alu_load_store_unit_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),         // see packing above
        .i_s_axis_tuser  (tx_item.special_flag),  // special_flag[0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // write_enable[0], write_index[5:1], write_value[37:6]
        .o_m_axis_tuser  (o_m_axis_tuser)   // write_special[0]
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // predicted write-back of one instruction, scratchpad updated on a store
    function automatic t_wb execute_instr(t_instr ins);
        t_wb         wb;
        logic [31:0] v;
        logic [31:0] addr_sum;
        logic [4:0]  sh;
        int          sa;
        int          sb;
        int          base;
        v        = '0;
        wb       = '0;
        wb.we    = 1'b1;
        sa       = ins.src_a;
        sb       = ins.src_b;
        sh       = ins.src_b[4:0];
        addr_sum = ins.src_a + ins.addr_offset;
        base     = addr_sum % salsu_pkg::MEM_BYTES;
        case (ins.mode)
            salsu_pkg::MODE_ADD: v = ins.src_a + ins.src_b;
            salsu_pkg::MODE_SUB: v = ins.src_a - ins.src_b;
            salsu_pkg::MODE_MUL: v = ins.src_a * ins.src_b;
            salsu_pkg::MODE_DIV, salsu_pkg::MODE_MOD: begin
                n_divmod++;
                // zero divisor: quotient all ones, remainder is the dividend
                if (ins.src_b == '0)
                    v = (ins.mode == salsu_pkg::MODE_DIV) ? 32'hffff_ffff : ins.src_a;
                else if (ins.src_a == 32'h8000_0000 && ins.src_b == 32'hffff_ffff)
                    v = (ins.mode == salsu_pkg::MODE_DIV) ? 32'h8000_0000 : 32'h0;
                else
                    v = (ins.mode == salsu_pkg::MODE_DIV) ? sa / sb : sa % sb;
            end
            salsu_pkg::MODE_SLL: v = ins.src_a << sh;
            salsu_pkg::MODE_SRL: v = ins.src_a >> sh;
            salsu_pkg::MODE_SRA: v = sa >>> sh;
            salsu_pkg::MODE_MIN: v = (sa < sb) ? ins.src_a : ins.src_b;
            salsu_pkg::MODE_LUI: v = ins.src_b << salsu_pkg::LUI_SHIFT;
            salsu_pkg::MODE_LOAD: begin
                n_load++;
                // each byte address wraps on its own
                for (int k = 0; k < 4; k++)
                    v[8*k +: 8] = spad_model[(base + k) % salsu_pkg::MEM_BYTES];
            end
            salsu_pkg::MODE_ASSIGN: begin
                v          = ins.src_a;
                wb.special = ins.special_flag;
            end
            salsu_pkg::MODE_STORE: begin
                n_store++;
                for (int k = 0; k < 4; k++)
                    spad_model[(base + k) % salsu_pkg::MEM_BYTES] = ins.src_b[8*k +: 8];
                wb.we = 1'b0;
            end
            default: begin
                n_unused++;
                wb.we = 1'b0;
            end
        endcase
        if (wb.we) begin
            wb.index = ins.dest_index;
            wb.value = v;
        end
        return wb;
    endfunction

    function automatic t_instr mk(logic [3:0] mode, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] off, logic [4:0] dest, logic spec);
        t_instr ins;
        ins.drain        = 1'b0;
        ins.mode         = mode;
        ins.src_a        = a;
        ins.src_b        = b;
        ins.addr_offset  = off;
        ins.dest_index   = dest;
        ins.special_flag = spec;
        return ins;
    endfunction

    // operands biased toward the values that matter for divide and compare
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'h1;
            2:       return 32'hffff_ffff;
            3:       return 32'h8000_0000;
            4:       return 32'h7fff_ffff;
            5:       return 32'($urandom_range(0, 64)) - 32'd32;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, what, want, got);
    endtask

    // driver: one beat at a time from the instruction queue
    always @(posedge i_clk) begin : driver
        logic took;
        logic drained;
        logic calm;
        if (!rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            took = tx_valid && o_s_axis_tready;
            calm = taken_cnt >= item_total - CALM_ITEMS;
            if (took) begin
                expected_writebacks.push_back(execute_instr(tx_item));
                taken_cnt <= taken_cnt + 1;
            end
            if (took || !tx_valid) begin
                // all write-backs in, and no beat taken at this very edge
                drained = (taken_cnt == results_seen) && !took;
                if (tx_gap > 0) begin
                    tx_gap--;
                    tx_valid <= 1'b0;
                end else if (instr_queue.size() != 0 && (!instr_queue[0].drain || drained)) begin
                    tx_item  <= instr_queue.pop_front();
                    tx_valid <= 1'b1;
                    tx_offered++;
                    if (tx_offered % 32 == 0)
                        tx_idle_on = $urandom_range(0, 2) != 0;
                    tx_gap = (tx_idle_on && !calm && $urandom_range(0, 2) == 0) ?
                             $urandom_range(1, 14) : 0;
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall bursts plus two long hold-offs
    always @(posedge i_clk) begin : receiver
        logic ready_next;
        logic calm;
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            calm = results_seen >= item_total - CALM_ITEMS;
            if (hold_left == 0 && !calm && results_seen >= next_hold_at) begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                ready_next = 1'b0;
            end else if (rx_idle_on && !calm && $urandom_range(0, 5) == 0) begin
                rx_stall   = $urandom_range(1, 14) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_idle_on = $urandom_range(0, 2) != 0;
            rx_ready <= ready_next;
        end
    end

    // monitor: every write-back beat against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_wb got;
        t_wb want;
        if (rst_n && o_m_axis_tvalid && rx_ready) begin
            got.we      = o_m_axis_tdata[0];
            got.index   = o_m_axis_tdata[5:1];
            got.value   = o_m_axis_tdata[37:6];
            got.special = o_m_axis_tuser[0];
            results_seen <= results_seen + 1;
            if (expected_writebacks.size() == 0) begin
                report("write-back with nothing pending", '0, got.value);
            end else begin
                want = expected_writebacks.pop_front();
                if (got.we !== want.we)
                    report("write_enable", want.we, got.we);
                if (got.index !== want.index)
                    report("write_index", want.index, got.index);
                if (got.value !== want.value)
                    report("write_value", want.value, got.value);
                if (got.special !== want.special)
                    report("write_special", want.special, got.special);
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin : watchdog
        if (rst_n) begin
            if ((tx_valid && o_s_axis_tready) || (o_m_axis_tvalid && rx_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_instr ins;
        int     target;
        int     r;
        int     stored_addrs[$];

        // directed: wrap, overflow and the divide corner cases
        instr_queue.push_back(mk(salsu_pkg::MODE_ADD, 32'h7fff_ffff, 32'h1, '0, 5'd31, 1'b1));
        instr_queue.push_back(mk(salsu_pkg::MODE_SUB, 32'h8000_0000, 32'h1, 32'hffff_ffff,
                                 5'd0, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_MUL, 32'h1234_5678, 32'h9abc_def0, '0,
                                 5'd21, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_DIV, 32'd12345, 32'h0, '0, 5'd10, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff, '0,
                                 5'd11, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_DIV, 32'hffff_fff9, 32'h2, '0, 5'd12, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_MOD, 32'hffff_fffb, 32'h0, '0, 5'd13, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_MOD, 32'h8000_0000, 32'hffff_ffff, '0,
                                 5'd14, 1'b1));
        instr_queue.push_back(mk(salsu_pkg::MODE_MOD, 32'hffff_fff9, 32'h2, '0, 5'd15, 1'b0));
        // shift amounts take only the low five bits
        instr_queue.push_back(mk(salsu_pkg::MODE_SLL, 32'h1, 32'hffff_ffff, '0, 5'd1, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_SRL, 32'h8000_0000, 32'hffff_ffe1, '0,
                                 5'd2, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_SRA, 32'h8000_0000, 32'd31, '0, 5'd3, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_SRA, 32'h8000_0001, 32'd32, '0, 5'd4, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_MIN, 32'hffff_ffff, 32'h1, '0, 5'd6, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_MIN, 32'h7fff_ffff, 32'h8000_0000, '0,
                                 5'd7, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_LUI, '0, 32'hffff_ffff, '0, 5'd8, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_ASSIGN, 32'hdead_beef, '0, '0, 5'd0, 1'b1));
        instr_queue.push_back(mk(salsu_pkg::MODE_ASSIGN, 32'h0bad_cafe, '0, '0, 5'd31, 1'b0));
        // word straddling the top of the scratchpad, address sum overflows
        instr_queue.push_back(mk(salsu_pkg::MODE_STORE, 32'hffff_ffff, 32'ha5c3_3c5a,
                                 32'hffff_ffff, 5'd31, 1'b1));
        instr_queue.push_back(mk(salsu_pkg::MODE_LOAD, '0, 32'hffff_ffff, 32'hffff_fffe,
                                 5'd9, 1'b1));
        instr_queue.push_back(mk(salsu_pkg::MODE_LOAD, 32'd4095, '0, '0, 5'd16, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_LOAD, 32'd2048, '0, 32'h8000_0000,
                                 5'd17, 1'b0));
        instr_queue.push_back(mk(salsu_pkg::MODE_STORE, 32'h7fff_ffff, 32'hffff_ffff,
                                 32'h7fff_ffff, 5'd18, 1'b0));
        instr_queue.push_back(mk(MODE_RSVD_LO, $urandom, $urandom, $urandom, 5'd19, 1'b1));
        instr_queue.push_back(mk(MODE_RSVD_HI, $urandom, $urandom, $urandom, 5'd20, 1'b1));

        // random: mostly arithmetic, with stores and loads aimed at written words
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r   = $urandom_range(0, 99);
            ins = mk(4'($urandom_range(salsu_pkg::MODE_ADD, salsu_pkg::MODE_ASSIGN)),
                     pick_operand(), pick_operand(), $urandom, 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)));
            if (ins.mode == salsu_pkg::MODE_LOAD)
                ins.mode = salsu_pkg::MODE_ASSIGN;
            if (r < 32) begin
                if (r < 15) begin
                    ins.mode = salsu_pkg::MODE_STORE;
                    ins.src_b = $urandom;
                    target = ($urandom_range(0, 3) == 0) ?
                             (salsu_pkg::MEM_BYTES - 4 + $urandom_range(0, 6)) %
                             salsu_pkg::MEM_BYTES :
                             $urandom_range(0, salsu_pkg::MEM_BYTES - 1);
                    stored_addrs.push_back(target);
                end else begin
                    ins.mode = salsu_pkg::MODE_LOAD;
                    if (stored_addrs.size() != 0 && $urandom_range(0, 3) != 0)
                        target = (stored_addrs[$urandom_range(0, stored_addrs.size() - 1)] +
                                  $urandom_range(0, 2)) % salsu_pkg::MEM_BYTES;
                    else
                        target = $urandom_range(0, salsu_pkg::MEM_BYTES - 1);
                end
                // base register plus offset, either small offset or a full random split
                if ($urandom_range(0, 2) == 0) begin
                    ins.addr_offset = 32'($urandom_range(0, 15)) - 32'd8;
                    ins.src_a = (32'(target) | ($urandom << salsu_pkg::ADDR_W)) -
                                ins.addr_offset;
                end else begin
                    ins.src_a = $urandom;
                    ins.addr_offset = (32'(target) | ($urandom << salsu_pkg::ADDR_W)) -
                                      ins.src_a;
                end
            end else if (r < 35) begin
                ins.mode = 4'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
            end else if (ins.mode inside {salsu_pkg::MODE_SLL, salsu_pkg::MODE_SRL,
                                          salsu_pkg::MODE_SRA}) begin
                ins.src_b = $urandom;
            end
            // sender pauses until the block has drained
            ins.drain = (n % 100 == 50) || (n == 0);
            instr_queue.push_back(ins);
        end
        item_total = instr_queue.size();

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        while (taken_cnt != item_total)
            @(posedge i_clk);
        while (expected_writebacks.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_writebacks.size() != 0) begin
            $display("%0t: %0d write-backs never arrived", $time, expected_writebacks.size());
            mismatches += expected_writebacks.size();
        end
        $display("ran %0d instructions: %0d loads, %0d stores, %0d div/mod, %0d unused codes",
                 taken_cnt, n_load, n_store, n_divmod, n_unused);
        $display("%0d write-back beats checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
